FILE: rtl/cfsc_pkg.sv
// ----------------------------------------------------------------------------
// cfsc_pkg
// Shared types and constants of the command frame sender.
// ----------------------------------------------------------------------------
package cfsc_pkg;

  // Input item kinds, carried on s_axis_tuser
  localparam logic [1:0] FuncHdr  = 2'd0;
  localparam logic [1:0] FuncByte = 2'd1;
  localparam logic [1:0] FuncPoll = 2'd2;

  // Result kinds, carried on m_axis_tuser
  localparam logic [1:0] KindWord = 2'd0;
  localparam logic [1:0] KindDone = 2'd1;
  localparam logic [1:0] KindTout = 2'd2;

  localparam logic [15:0] MagicWord      = 16'hABCD;
  localparam logic [15:0] SizeBase       = 16'd16;
  localparam logic [15:0] PollLimitReset = 16'hFFFF;

  // Register map (index of the register, byte address is 4 * index)
  localparam logic RegPollLimit = 1'b0;

  localparam int unsigned QueueDepth = 2;

  // Header word sequence: magic, cmd, size, token halves, argument halves, sum
  localparam logic [3:0] StepLastArg = 4'd10;
  localparam logic [3:0] StepHdrSum  = 4'd11;
  localparam logic [3:0] StepWordSum = 4'd1;

  typedef enum logic [1:0] {
    OP_HDR  = 2'd0,
    OP_WORD = 2'd1,
    OP_DONE = 2'd2,
    OP_TOUT = 2'd3
  } op_e;

  // Command handed from the front to the back through the queue
  typedef struct packed {
    op_e         op;
    logic        fin;     // close the frame with the checksum word
    logic [15:0] word;    // packed payload word
    logic [7:0]  cmd_id;
    logic [15:0] size;
    logic [31:0] seed;
    logic [31:0] arg0;
    logic [31:0] arg1;
    logic [31:0] arg2;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_POLL    = 3'b100
  } phase_e;

endpackage

FILE: rtl/cfsc_front.sv
// ----------------------------------------------------------------------------
// cfsc_front
// Accepts input items, tracks the frame phase and issues commands.
// ----------------------------------------------------------------------------
module cfsc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          func_i,
  input  logic [7:0]          cmd_id_i,
  input  logic [31:0]         arg0_i,
  input  logic [31:0]         arg1_i,
  input  logic [31:0]         arg2_i,
  input  logic [11:0]         buf_len_i,
  input  logic [31:0]         token_seed_i,
  input  logic [7:0]          data_byte_i,
  input  logic [31:0]         token_read_i,
  input  logic [15:0]         poll_limit_i,
  output logic                push_o,
  output cfsc_pkg::cmd_t      push_cmd_o
);

  cfsc_pkg::phase_e phase_q, phase_d;
  logic [11:0] bytes_left_q, bytes_left_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic        have_held_q, have_held_d;
  logic [31:0] expected_q, expected_d;
  logic [15:0] polls_left_q, polls_left_d;

  logic [12:0] len_even;
  logic [11:0] bytes_next;

  assign len_even   = ({1'b0, buf_len_i} + {12'd0, buf_len_i[0]}) & 13'h1FFE;
  assign bytes_next = bytes_left_q - 12'd1;

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    held_byte_d  = held_byte_q;
    have_held_d  = have_held_q;
    expected_d   = expected_q;
    polls_left_d = polls_left_q;
    push_o       = 1'b0;

    push_cmd_o        = '0;
    push_cmd_o.op     = cfsc_pkg::OP_HDR;
    push_cmd_o.cmd_id = cmd_id_i;
    push_cmd_o.size   = cfsc_pkg::SizeBase + {3'd0, len_even};
    push_cmd_o.seed   = token_seed_i;
    push_cmd_o.arg0   = arg0_i;
    push_cmd_o.arg1   = arg1_i;
    push_cmd_o.arg2   = arg2_i;

    if (accept_i) begin
      if (func_i == cfsc_pkg::FuncHdr && phase_q == cfsc_pkg::PH_IDLE) begin
        push_o         = 1'b1;
        push_cmd_o.fin = (buf_len_i == 12'd0);
        expected_d     = {token_seed_i[15:0], token_seed_i[31:16]};
        bytes_left_d   = buf_len_i;
        have_held_d    = 1'b0;
        held_byte_d    = 8'd0;
        if (buf_len_i == 12'd0) begin
          phase_d      = cfsc_pkg::PH_POLL;
          polls_left_d = poll_limit_i;
        end else begin
          phase_d = cfsc_pkg::PH_PAYLOAD;
        end
      end else if (func_i == cfsc_pkg::FuncByte && phase_q == cfsc_pkg::PH_PAYLOAD) begin
        bytes_left_d = bytes_next;
        if (have_held_q) begin
          push_o          = 1'b1;
          push_cmd_o.op   = cfsc_pkg::OP_WORD;
          push_cmd_o.word = {held_byte_q, data_byte_i};
          push_cmd_o.fin  = (bytes_next == 12'd0);
          have_held_d     = 1'b0;
          held_byte_d     = 8'd0;
        end else if (bytes_next == 12'd0) begin
          push_o          = 1'b1;
          push_cmd_o.op   = cfsc_pkg::OP_WORD;
          push_cmd_o.word = {data_byte_i, 8'd0};
          push_cmd_o.fin  = 1'b1;
        end else begin
          held_byte_d = data_byte_i;
          have_held_d = 1'b1;
        end
        if (push_cmd_o.fin) begin
          phase_d      = cfsc_pkg::PH_POLL;
          polls_left_d = poll_limit_i;
        end
      end else if (func_i == cfsc_pkg::FuncPoll && phase_q == cfsc_pkg::PH_POLL) begin
        if (token_read_i == expected_q) begin
          push_o        = 1'b1;
          push_cmd_o.op = cfsc_pkg::OP_DONE;
          phase_d       = cfsc_pkg::PH_IDLE;
        end else if (polls_left_q <= 16'd1) begin
          push_o        = 1'b1;
          push_cmd_o.op = cfsc_pkg::OP_TOUT;
          polls_left_d  = 16'd0;
          phase_d       = cfsc_pkg::PH_IDLE;
        end else begin
          polls_left_d = polls_left_q - 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= cfsc_pkg::PH_IDLE;
      bytes_left_q <= 12'd0;
      held_byte_q  <= 8'd0;
      have_held_q  <= 1'b0;
      expected_q   <= 32'd0;
      polls_left_q <= 16'd0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      held_byte_q  <= held_byte_d;
      have_held_q  <= have_held_d;
      expected_q   <= expected_d;
      polls_left_q <= polls_left_d;
    end
  end

endmodule

FILE: rtl/cfsc_queue.sv
// ----------------------------------------------------------------------------
// cfsc_queue
// Small first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
module cfsc_queue #(
  parameter int unsigned Depth = cfsc_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cfsc_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output cfsc_pkg::cmd_t head_o,
  output logic           head_valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cfsc_pkg::cmd_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/cfsc_back.sv
// ----------------------------------------------------------------------------
// cfsc_back
// Expands commands into bus words, keeps the checksum, drives the output.
// ----------------------------------------------------------------------------
module cfsc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfsc_pkg::cmd_t head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [15:0]    out_word_o,
  output logic [1:0]     out_kind_o,
  output logic           out_last_o
);

  logic [3:0]  step_q, step_d;
  logic [15:0] sum_q, sum_d;
  logic        valid_q, valid_d;
  logic [15:0] word_q, word_d;
  logic [1:0]  kind_q, kind_d;
  logic        last_q, last_d;
  logic        emit, final_step, is_sum;

  assign emit = head_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    word_d     = word_q;
    kind_d     = kind_q;
    last_d     = last_q;
    sum_d      = sum_q;
    final_step = 1'b0;
    is_sum     = 1'b0;

    case (head_i.op)
      cfsc_pkg::OP_HDR: begin
        final_step = head_i.fin ? (step_q == cfsc_pkg::StepHdrSum)
                                : (step_q == cfsc_pkg::StepLastArg);
        is_sum     = (step_q == cfsc_pkg::StepHdrSum);
      end
      cfsc_pkg::OP_WORD: begin
        final_step = head_i.fin ? (step_q == cfsc_pkg::StepWordSum) : (step_q == 4'd0);
        is_sum     = (step_q == cfsc_pkg::StepWordSum);
      end
      default: begin
        final_step = 1'b1;
      end
    endcase

    if (emit) begin
      kind_d = cfsc_pkg::KindWord;
      last_d = is_sum;
      case (head_i.op)
        cfsc_pkg::OP_HDR: begin
          case (step_q)
            4'd0:    word_d = cfsc_pkg::MagicWord;
            4'd1:    word_d = {8'd0, head_i.cmd_id};
            4'd2:    word_d = head_i.size;
            4'd3:    word_d = head_i.seed[15:0];
            4'd4:    word_d = head_i.seed[31:16];
            4'd5:    word_d = head_i.arg0[15:0];
            4'd6:    word_d = head_i.arg0[31:16];
            4'd7:    word_d = head_i.arg1[15:0];
            4'd8:    word_d = head_i.arg1[31:16];
            4'd9:    word_d = head_i.arg2[15:0];
            4'd10:   word_d = head_i.arg2[31:16];
            default: word_d = sum_q;
          endcase
          // Restart the sum on the magic word, add every word up to the args
          if (step_q == 4'd0) begin
            sum_d = 16'd0;
          end else if (!is_sum) begin
            sum_d = sum_q + word_d;
          end
        end
        cfsc_pkg::OP_WORD: begin
          word_d = is_sum ? sum_q : head_i.word;
          if (!is_sum) begin
            sum_d = sum_q + head_i.word;
          end
        end
        cfsc_pkg::OP_DONE: begin
          kind_d = cfsc_pkg::KindDone;
          word_d = 16'd0;
          last_d = 1'b1;
        end
        default: begin
          kind_d = cfsc_pkg::KindTout;
          word_d = 16'd0;
          last_d = 1'b1;
        end
      endcase
    end
  end

  assign pop_o   = emit && final_step;
  assign step_d  = emit ? (final_step ? 4'd0 : step_q + 4'd1) : step_q;
  assign valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 4'd0;
      sum_q   <= 16'd0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      sum_q   <= sum_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;

endmodule

FILE: rtl/command_frame_sender_checksum_unit.sv
// ----------------------------------------------------------------------------
// command_frame_sender_checksum_unit
// Command frame builder with 16-bit checksum and completion token polling.
// ----------------------------------------------------------------------------
// A header item produces a frame of 16-bit words on the output stream: the
// magic word, the command, the padded payload size plus 16, the token halves
// and the argument halves, then payload words built from pairs of payload
// items (high byte first, an odd last byte padded with zero), and a closing
// checksum word marked with tlast. Poll items are then compared against the
// swapped seed; a match gives a done result, and running out of poll_limit
// polls gives a timeout result, both with tlast. Items that do not fit the
// current phase are dropped without a result. The input side accepts one
// item per cycle while the command queue (QUEUE_DEPTH entries) has room; the
// output side gives one word per cycle while m_axis_tready is high, so a
// header holds the word sequencer up to its last argument word, or its
// checksum with an empty payload, and payload items sustain one every cycle
// while the sequencer keeps up with one word per two bytes. poll_limit sits
// at byte address 0 and may be rewritten only while idle.
// ----------------------------------------------------------------------------
module command_frame_sender_checksum_unit #(
  parameter int unsigned QUEUE_DEPTH = cfsc_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: cmd_id[7:0], arg0[39:8], arg1[71:40], arg2[103:72],
  //        buf_len[115:104], token_seed[147:116], data_byte[155:148],
  //        token_read[187:156], zero pad[191:188]
  input  logic [191:0] s_axis_tdata,
  // tuser: func[1:0]
  input  logic [1:0]   s_axis_tuser,
  // Output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: out_word[15:0]
  output logic [15:0]  m_axis_tdata,
  // tuser: out_kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  // Configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [15:0]    poll_limit_q;
  logic           accept;
  logic           push, full, pop, head_valid;
  cfsc_pkg::cmd_t push_cmd, head;

  // Configuration: single register, always ready
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= cfsc_pkg::PollLimitReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == cfsc_pkg::RegPollLimit) begin
      poll_limit_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == cfsc_pkg::RegPollLimit) ? {16'd0, poll_limit_q} : 32'd0;

  // Hold off the input only when the queue is full
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cfsc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (s_axis_tuser),
    .cmd_id_i     (s_axis_tdata[7:0]),
    .arg0_i       (s_axis_tdata[39:8]),
    .arg1_i       (s_axis_tdata[71:40]),
    .arg2_i       (s_axis_tdata[103:72]),
    .buf_len_i    (s_axis_tdata[115:104]),
    .token_seed_i (s_axis_tdata[147:116]),
    .data_byte_i  (s_axis_tdata[155:148]),
    .token_read_i (s_axis_tdata[187:156]),
    .poll_limit_i (poll_limit_q),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  cfsc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  cfsc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_word_o   (m_axis_tdata),
    .out_kind_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

FILE: rtl/cfsc_checker.sv
// ----------------------------------------------------------------------------
// cfsc_checker
// Port-level checks of the command frame sender, bound to the top level.
// ----------------------------------------------------------------------------
module cfsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // Status results close with tlast and carry a zero word
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != cfsc_pkg::KindWord |->
      m_axis_tlast && m_axis_tdata == 16'd0)
    else $error("status result without tlast or with a non-zero word");

  // No unused result kind
  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tuser == cfsc_pkg::KindWord || m_axis_tuser == cfsc_pkg::KindDone
      || m_axis_tuser == cfsc_pkg::KindTout)
    else $error("unknown result kind");

  // Read back the limit just written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(psel && penable && pwrite && paddr[2] == cfsc_pkg::RegPollLimit)
      && paddr[2] == cfsc_pkg::RegPollLimit |->
      prdata == {16'd0, $past(pwdata[15:0])})
    else $error("poll limit readback mismatch");

endmodule

bind command_frame_sender_checksum_unit cfsc_checker u_cfsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);
